// ===== rtl/biquad_iir_filter_macros.svh =====
// assertion macros for the biquad filter
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BIQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad assertion failed");
// antecedent implies consequent in the next cycle
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad assertion failed");
`else
`define BIQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/biq_pkg.sv =====
// shared constants and types for the biquad filter
`default_nettype none

package biq_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 20;
  localparam int MID_BITS        = 32;
  localparam int ACC_BITS        = 64;
  localparam int NUM_REGS        = 6;
  localparam int CFG_IDX_BITS    = 3;

  // coefficient register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RA = 3'd5;

  // multiplier operand selection
  typedef enum logic [2:0] {
    TERM_B0    = 3'd0,
    TERM_B1    = 3'd1,
    TERM_B2    = 3'd2,
    TERM_A1    = 3'd3,
    TERM_A2    = 3'd4,
    TERM_SCALE = 3'd5
  } term_t;

  typedef struct packed {
    logic  load_in;
    logic  mul_en;
    term_t mul_sel;
    logic  acc_en;
    logic  acc_first;
    logic  mid_load;
    logic  commit;
  } biq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/biq_datapath.sv =====
// biquad datapath: coefficients, filter memory, shared multiplier, accumulator, rounding
`default_nettype none

module biq_datapath #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [COEF_BITS-1:0]              cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                              in_last,
  input  wire biq_pkg::biq_cmd_t                 cmd,
  output logic signed [SAMPLE_BITS-1:0]          out_sample,
  output logic                                   out_last
);

  localparam int COEF_FRAC  = COEF_BITS - 4;
  localparam int MUL_A_BITS = biq_pkg::MID_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + COEF_BITS;
  localparam int ACC_BITS   = biq_pkg::ACC_BITS;
  localparam int MID_BITS   = biq_pkg::MID_BITS;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    {{(COEF_BITS-1){1'b0}}, 1'b1} << COEF_FRAC;
  localparam logic signed [ACC_BITS-1:0] HALF =
    {{(ACC_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);
  localparam logic signed [ACC_BITS-1:0] MID_HI =
    ({{(ACC_BITS-1){1'b0}}, 1'b1} << (MID_BITS - 1)) - 1;
  localparam logic signed [ACC_BITS-1:0] MID_LO = ~MID_HI;
  localparam logic signed [ACC_BITS-1:0] SMP_HI =
    ({{(ACC_BITS-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_BITS-1:0] SMP_LO = ~SMP_HI;

  logic signed [COEF_BITS-1:0]   coef_r [biq_pkg::NUM_REGS];
  logic signed [SAMPLE_BITS-1:0] x_r, x1_r, x2_r, y1_r, y2_r;
  logic                          last_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic                          prod_sub_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [MID_BITS-1:0]    mid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;

  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [COEF_BITS-1:0]   mul_b;
  logic                          mul_sub;
  logic signed [ACC_BITS-1:0]    prod_ext, acc_term;
  logic signed [ACC_BITS-1:0]    rnd_acc, rnd_prod;
  logic signed [MID_BITS-1:0]    mid_nxt;
  logic signed [SAMPLE_BITS-1:0] y_fin;

  // coefficient registers, out of range writes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[biq_pkg::REG_B0] <= COEF_ONE;
      coef_r[biq_pkg::REG_B1] <= '0;
      coef_r[biq_pkg::REG_B2] <= '0;
      coef_r[biq_pkg::REG_A1] <= '0;
      coef_r[biq_pkg::REG_A2] <= '0;
      coef_r[biq_pkg::REG_RA] <= COEF_ONE;
    end else if (cfg_wr_en && (cfg_index < biq_pkg::CFG_IDX_BITS'(biq_pkg::NUM_REGS))) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sub = 1'b0;
    case (cmd.mul_sel)
      biq_pkg::TERM_B0: begin
        mul_a = MUL_A_BITS'(x_r);
        mul_b = coef_r[biq_pkg::REG_B0];
      end
      biq_pkg::TERM_B1: begin
        mul_a = MUL_A_BITS'(x1_r);
        mul_b = coef_r[biq_pkg::REG_B1];
      end
      biq_pkg::TERM_B2: begin
        mul_a = MUL_A_BITS'(x2_r);
        mul_b = coef_r[biq_pkg::REG_B2];
      end
      biq_pkg::TERM_A1: begin
        mul_a   = MUL_A_BITS'(y1_r);
        mul_b   = coef_r[biq_pkg::REG_A1];
        mul_sub = 1'b1;
      end
      biq_pkg::TERM_A2: begin
        mul_a   = MUL_A_BITS'(y2_r);
        mul_b   = coef_r[biq_pkg::REG_A2];
        mul_sub = 1'b1;
      end
      biq_pkg::TERM_SCALE: begin
        mul_a = mid_r;
        mul_b = coef_r[biq_pkg::REG_RA];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    prod_ext = ACC_BITS'(prod_r);
    acc_term = prod_sub_r ? -prod_ext : prod_ext;
    // round half up, then saturate to the intermediate width
    rnd_acc  = (acc_r + HALF) >>> COEF_FRAC;
    if (rnd_acc > MID_HI) begin
      mid_nxt = MID_HI[MID_BITS-1:0];
    end else if (rnd_acc < MID_LO) begin
      mid_nxt = MID_LO[MID_BITS-1:0];
    end else begin
      mid_nxt = rnd_acc[MID_BITS-1:0];
    end
    // prod_r holds mid * recip_a0 when the result is committed
    rnd_prod = (prod_ext + HALF) >>> COEF_FRAC;
    if (rnd_prod > SMP_HI) begin
      y_fin = SMP_HI[SAMPLE_BITS-1:0];
    end else if (rnd_prod < SMP_LO) begin
      y_fin = SMP_LO[SAMPLE_BITS-1:0];
    end else begin
      y_fin = rnd_prod[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r     <= mul_a * mul_b;
      prod_sub_r <= mul_sub;
    end
    if (cmd.acc_en) begin
      acc_r <= cmd.acc_first ? acc_term : acc_r + acc_term;
    end
    if (cmd.mid_load) begin
      mid_r <= mid_nxt;
    end
    if (cmd.load_in) begin
      x_r    <= in_sample;
      last_r <= in_last;
    end
    if (cmd.commit) begin
      out_sample_r <= y_fin;
      out_last_r   <= last_r;
    end
  end

  // filter memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (cmd.commit) begin
      x2_r <= x1_r;
      x1_r <= x_r;
      y2_r <= y1_r;
      y1_r <= y_fin;
    end
  end

  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/biq_ctrl.sv =====
// biquad sequencer: steps the shared multiplier and drives the output handshake
`default_nettype none

module biq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output biq_pkg::biq_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_TAIL  = 6'b000100,
    S_MID   = 6'b001000,
    S_SCALE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.mul_sel   = biq_pkg::TERM_B0;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = 3'(biq_pkg::TERM_B0);
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        // multiply this term while the previous product is summed
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = biq_pkg::term_t'(cnt_r);
        cmd.acc_en    = (cnt_r != 3'(biq_pkg::TERM_B0));
        cmd.acc_first = (cnt_r == 3'(biq_pkg::TERM_B1));
        cnt_nxt       = cnt_r + 3'd1;
        if (cnt_r == 3'(biq_pkg::TERM_A2)) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_MID;
      end
      S_MID: begin
        cmd.mid_load = 1'b1;
        state_nxt    = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biq_pkg::TERM_SCALE;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/biquad_iir_filter.sv =====
// Second-order direct form I IIR filter for signed audio samples. Each input
// transfer yields exactly one output transfer in order; the filter memory runs
// across tlast boundaries and tlast simply follows its sample. One sample is
// processed at a time: the next input is not taken until the current result
// is committed. A single shared multiplier is used for the five filter terms,
// followed by steps for the last sum and the intermediate rounding, then the
// multiplier does the reciprocal scaling and the final rounding is done as the
// result is committed. A finished sample waits in the output register, so work
// on the next sample goes on while downstream stalls. Coefficients are signed
// Q4.16 written through the cfg port; the user must write them only while idle,
// the block does not enforce this. b0 and the reciprocal of a0 reset to 1.0.
`default_nettype none
`include "biquad_iir_filter_macros.svh"

module biquad_iir_filter #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [biq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [COEF_BITS-1:0]                 cfg_wdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample_in
  input  wire logic                                 in_tlast,   // block_end_in
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]          out_tdata,  // sample_out
  output logic                                      out_tlast   // block_end_out
);

  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  biq_pkg::biq_cmd_t             cmd;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  biq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  biq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .out_sample (out_sample),
    .out_last   (out_tlast)
  );

  assign out_tdata = TDATA_BITS'(unsigned'(out_sample));

  `BIQ_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BIQ_ASSERT_IMPL(a_commit_slot_free, clk, rst_n, cmd.commit, !out_tvalid || out_tready)
  `BIQ_ASSERT_IMPL(a_idle_quiet, clk, rst_n, in_tready, !(cmd.mul_en || cmd.acc_en || cmd.commit))
  `BIQ_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_tvalid)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the biquad direct form I filter
`timescale 1ns / 100ps

module tb;

  localparam int SB        = biq_pkg::SAMPLE_BITS_DEF;
  localparam int CB        = biq_pkg::COEF_BITS_DEF;
  localparam int TDATA_W   = ((SB + 7) / 8) * 8;
  localparam int COEF_FRAC = CB - 4;
  localparam int WDOG_MAX  = 1500;
  localparam int TAIL_WAIT = 24;

  // indexes past the register file, writes there must not land anywhere
  localparam logic [biq_pkg::CFG_IDX_BITS-1:0] REG_SPARE0 =
    biq_pkg::CFG_IDX_BITS'(biq_pkg::NUM_REGS);
  localparam logic [biq_pkg::CFG_IDX_BITS-1:0] REG_SPARE1 =
    biq_pkg::CFG_IDX_BITS'(biq_pkg::NUM_REGS + 1);

  localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CB-1:0] CF_MAX  = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CF_MIN  = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] CF_ONE  = CB'(1 << COEF_FRAC);

  typedef struct packed {
    logic          last;
    logic [SB-1:0] sample;
  } audio_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [biq_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;  // sample_in
  logic in_tlast = 1'b0;              // block_end_in
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;      // sample_out
  logic out_tlast;                    // block_end_out

  always #2 clk = ~clk;

  biquad_iir_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  audio_item_t pending_samples[$];
  audio_item_t filtered_q[$];
  int n_offered = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  // filter copy: coefficients and direct form I history
  logic signed [CB-1:0] coef [biq_pkg::NUM_REGS];
  logic signed [SB-1:0] hist_x1 = '0, hist_x2 = '0, hist_y1 = '0, hist_y2 = '0;

  initial begin
    coef[biq_pkg::REG_B0] = CF_ONE;
    coef[biq_pkg::REG_B1] = '0;
    coef[biq_pkg::REG_B2] = '0;
    coef[biq_pkg::REG_A1] = '0;
    coef[biq_pkg::REG_A2] = '0;
    coef[biq_pkg::REG_RA] = CF_ONE;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic audio_item_t biquad_predict(logic [SB-1:0] smp, logic last);
    longint x, acc, mid, y;
    longint half;
    audio_item_t r;
    half = longint'(1) <<< (COEF_FRAC - 1);
    x = longint'($signed(smp));
    acc = longint'(coef[biq_pkg::REG_B0]) * x
        + longint'(coef[biq_pkg::REG_B1]) * longint'(hist_x1)
        + longint'(coef[biq_pkg::REG_B2]) * longint'(hist_x2)
        - longint'(coef[biq_pkg::REG_A1]) * longint'(hist_y1)
        - longint'(coef[biq_pkg::REG_A2]) * longint'(hist_y2);
    mid = clamp((acc + half) >>> COEF_FRAC, biq_pkg::MID_BITS);
    y = clamp((mid * longint'(coef[biq_pkg::REG_RA]) + half) >>> COEF_FRAC, SB);
    hist_x2 = hist_x1;
    hist_x1 = smp;
    hist_y2 = hist_y1;
    hist_y1 = y[SB-1:0];
    r.sample = y[SB-1:0];
    r.last = last;
    return r;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : drive_proc
    audio_item_t nxt;
    bit go;
    if (!(in_tvalid && n_accepted != n_offered)) begin
      go = 1'b0;
      if (pending_samples.size() != 0) begin
        if (no_idle) begin
          go = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          go = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30)
                                                   : $urandom_range(0, 4);
          end
        end
      end
      if (go) begin
        nxt = pending_samples.pop_front();
        in_tdata <= TDATA_W'(nxt.sample);
        in_tlast <= nxt.last;
        in_tvalid <= 1'b1;
        n_offered++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stalls of random length, now and then a long one
  int rx_hold = 0;

  always @(negedge clk) begin : rx_proc
    int pick;
    if (no_idle) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        rx_hold = $urandom_range(20, 60);
        out_tready <= 1'b0;
      end else if (pick < 4) begin
        rx_hold = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        rx_hold = $urandom_range(0, 20);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : mon_proc
    audio_item_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        filtered_q.push_back(biquad_predict(in_tdata[SB-1:0], in_tlast));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected output transfer, got sample %h last %b",
                   $time, out_tdata[SB-1:0], out_tlast);
          n_errors++;
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata[SB-1:0] !== want.sample) begin
            $display("%0t: sample_out mismatch, expected %h got %h",
                     $time, want.sample, out_tdata[SB-1:0]);
            n_errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: block_end_out mismatch, expected %b got %b",
                     $time, want.last, out_tlast);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : wdog_proc
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_sample(input logic [SB-1:0] s, input logic l);
    audio_item_t it;
    it.sample = s;
    it.last = l;
    pending_samples.push_back(it);
  endtask

  task automatic queue_random(input int n);
    logic [SB-1:0] s;
    int sel;
    s = '0;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0: s = SMP_MAX;
        1: s = SMP_MIN;
        2, 3: s = SB'($urandom_range(0, 4095)) - SB'(2048);
        4, 5: ;  // hold the last value, a step drives the feedback path
        default: s = SB'($urandom());
      endcase
      queue_sample(s, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || n_accepted != n_offered || filtered_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [biq_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [CB-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < biq_pkg::NUM_REGS) coef[idx] = val;
  endtask

  task automatic set_coefs(input logic [CB-1:0] b0, input logic [CB-1:0] b1,
                           input logic [CB-1:0] b2, input logic [CB-1:0] a1,
                           input logic [CB-1:0] a2, input logic [CB-1:0] ra);
    wait_drained();
    cfg_write(biq_pkg::REG_B0, b0);
    cfg_write(biq_pkg::REG_B1, b1);
    cfg_write(biq_pkg::REG_B2, b2);
    cfg_write(biq_pkg::REG_A1, a1);
    cfg_write(biq_pkg::REG_A2, a2);
    cfg_write(biq_pkg::REG_RA, ra);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CB-1:0] rand_coef(input int lo, input int hi);
    return CB'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic logic [CB-1:0] rand_extreme();
    return ($urandom_range(0, 1) != 0) ? CF_MAX : CF_MIN;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset coefficients pass the sample straight through
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b1);
    queue_sample('0, 1'b0);
    queue_sample(SB'(1), 1'b0);
    queue_sample({SB{1'b1}}, 1'b1);
    queue_sample(SB'($urandom()), 1'b0);

    // tiny gain puts samples on rounding ties, spare indexes must be ignored
    set_coefs(CB'(1), '0, '0, '0, '0, CF_ONE);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPARE0;
    cfg_wdata <= CB'($urandom());
    @(negedge clk);
    cfg_index <= REG_SPARE1;
    cfg_wdata <= CB'($urandom());
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    queue_sample(SB'(32768), 1'b0);
    queue_sample(-SB'(32768), 1'b0);
    queue_sample(SB'(98304), 1'b1);
    queue_sample(-SB'(98304), 1'b0);
    queue_sample(SB'(32767), 1'b0);

    // extreme coefficients drive the output into saturation both ways
    set_coefs(CF_MAX, CF_MIN, CF_MAX, CF_MIN, CF_MAX, CF_MIN);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b1);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(SMP_MAX, 1'b1);

    set_coefs(CF_MIN, CF_MIN, CF_MIN, CF_MIN, CF_MIN, CF_MAX);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b1);
    queue_sample('0, 1'b0);

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: set_coefs(CB'($urandom()), CB'($urandom()), CB'($urandom()),
                     CB'($urandom()), CB'($urandom()), CB'($urandom()));
        1, 3: set_coefs(rand_coef(-32768, 32768), rand_coef(-32768, 32768),
                        rand_coef(-32768, 32768), rand_coef(-120000, 120000),
                        rand_coef(0, 60000), rand_coef(32768, 98304));
        default: set_coefs(rand_extreme(), rand_extreme(), rand_extreme(),
                           rand_extreme(), rand_extreme(), rand_extreme());
      endcase
      no_idle = (p == 5 || p == 10);
      queue_random(150);
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0 && filtered_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
